### rtl/crmap_pkg.sv
// Shared types, sizes and codes for the chunk range address map.
package crmap_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int COUNT_W     = $clog2(MAX_ENTRIES + 1);
    localparam int ADDR_W      = 64;
    localparam int STRIPE_W    = 16;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_ADD    = 1'b1;

    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_UNSUPPORTED = 2'd1;
    localparam logic [1:0] STATUS_FULL        = 2'd2;

    localparam logic [STRIPE_W-1:0] STRIPES_SUPPORTED = STRIPE_W'(1);

    typedef struct packed {
        logic [ADDR_W-1:0] logical;
        logic [ADDR_W-1:0] length;
        logic [ADDR_W-1:0] physical;
    } entry_t;

    // Control that travels with one entry through the scan pipeline.
    typedef struct packed {
        logic valid;
        logic last;
    } stage_t;

    typedef struct packed {
        logic valid;
        logic last;
        logic hit;
    } match_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

endpackage

### rtl/crmap_table.sv
// Range table storage: one write port, one registered read port.
module crmap_table (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [crmap_pkg::IDX_W-1:0]   wr_addr,
    input  crmap_pkg::entry_t             wr_data,
    input  logic                          rd_en,
    input  logic [crmap_pkg::IDX_W-1:0]   rd_addr,
    input  crmap_pkg::stage_t             rd_ctrl,
    input  logic                          flush,
    output crmap_pkg::entry_t             rd_data,
    output crmap_pkg::stage_t             rd_ctrl_out
);

    crmap_pkg::entry_t mem [crmap_pkg::MAX_ENTRIES];
    crmap_pkg::entry_t rd_data_reg;
    crmap_pkg::stage_t ctrl_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (flush)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg.valid <= rd_ctrl.valid;
            ctrl_reg.last  <= rd_ctrl.last;
        end
    end

    assign rd_data     = rd_data_reg;
    assign rd_ctrl_out = ctrl_reg;

endmodule

### rtl/crmap_match.sv
// Shared range test and translate unit with registered operands, one entry per cycle.
module crmap_match (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          flush,
    input  crmap_pkg::stage_t             ctrl_in,
    input  crmap_pkg::entry_t             entry,
    input  logic [crmap_pkg::ADDR_W-1:0]  addr,
    output crmap_pkg::match_t             result,
    output logic [crmap_pkg::ADDR_W-1:0]  sum
);

    logic [crmap_pkg::ADDR_W:0]   diff_wide;
    logic [crmap_pkg::ADDR_W-1:0] end_reg;
    logic [crmap_pkg::ADDR_W-1:0] diff_reg;
    logic [crmap_pkg::ADDR_W-1:0] phys_reg;
    logic                         ge_reg;
    crmap_pkg::stage_t            ctrl_reg;

    // borrow out of addr - start means addr < start
    assign diff_wide = {1'b0, addr} - {1'b0, entry.logical};

    always_ff @(posedge clk)
    begin
        end_reg  <= entry.logical + entry.length;
        diff_reg <= diff_wide[crmap_pkg::ADDR_W-1:0];
        ge_reg   <= ~diff_wide[crmap_pkg::ADDR_W];
        phys_reg <= entry.physical;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (flush)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    assign result.valid = ctrl_reg.valid;
    assign result.last  = ctrl_reg.last;
    assign result.hit   = ctrl_reg.valid && ge_reg && (addr < end_reg);
    assign sum          = phys_reg + diff_reg;

endmodule

### rtl/chunk_range_address_map_unit.sv
// Add an entry to the range table or map a logical address to a physical one.
// An add item or a lookup on an empty table goes straight to the finish state; a lookup
// scans the entries in order until a hit or the last entry; one entry is scanned a cycle.
// One item is in work at a time; the next is accepted once its result enters the output register;
// in_ready does not wait for out_ready, a finished result waits for the output register.
// Reset clears the entry count and control; table contents stay undefined until written.
module chunk_range_address_map_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              op,
    input  logic [crmap_pkg::ADDR_W-1:0]      logical_addr,
    input  logic [crmap_pkg::ADDR_W-1:0]      range_length,
    input  logic [crmap_pkg::ADDR_W-1:0]      physical_start,
    input  logic [crmap_pkg::STRIPE_W-1:0]    stripe_count,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              found,
    output logic [crmap_pkg::ADDR_W-1:0]      physical_addr,
    output logic [1:0]                        status
);

    crmap_pkg::state_t state_reg, state_next;
    logic [crmap_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [crmap_pkg::COUNT_W-1:0] issue_reg, issue_next;
    logic [crmap_pkg::ADDR_W-1:0]  addr_reg, addr_next;

    logic                          res_found_reg, res_found_next;
    logic [crmap_pkg::ADDR_W-1:0]  res_phys_reg, res_phys_next;
    logic [1:0]                    res_status_reg, res_status_next;

    logic                          out_valid_reg;
    logic                          found_reg;
    logic [crmap_pkg::ADDR_W-1:0]  phys_out_reg;
    logic [1:0]                    status_reg;

    logic                          in_fire;
    logic                          out_free;
    logic                          load_out;
    logic                          wr_en;
    logic                          rd_en;
    logic                          flush;
    logic                          scan_done;
    crmap_pkg::entry_t             wr_data;
    crmap_pkg::entry_t             rd_data;
    crmap_pkg::stage_t             issue_ctrl;
    crmap_pkg::stage_t             rd_ctrl;
    crmap_pkg::match_t             match;
    logic [crmap_pkg::ADDR_W-1:0]  match_sum;

    assign in_ready = (state_reg == crmap_pkg::ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign load_out = (state_reg == crmap_pkg::ST_FINISH) && out_free;

    assign wr_en   = in_fire && (op == crmap_pkg::OP_ADD)
                     && (stripe_count == crmap_pkg::STRIPES_SUPPORTED)
                     && (count_reg < crmap_pkg::COUNT_W'(crmap_pkg::MAX_ENTRIES));
    assign wr_data = '{logical: logical_addr, length: range_length,
                       physical: physical_start};

    assign rd_en            = (state_reg == crmap_pkg::ST_SCAN) && (issue_reg < count_reg);
    assign issue_ctrl.valid = rd_en;
    assign issue_ctrl.last  = ((issue_reg + crmap_pkg::COUNT_W'(1)) == count_reg);

    assign scan_done = (state_reg == crmap_pkg::ST_SCAN) && match.valid
                       && (match.hit || match.last);
    assign flush     = scan_done;

    crmap_table u_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (wr_en),
        .wr_addr     (count_reg[crmap_pkg::IDX_W-1:0]),
        .wr_data     (wr_data),
        .rd_en       (rd_en),
        .rd_addr     (issue_reg[crmap_pkg::IDX_W-1:0]),
        .rd_ctrl     (issue_ctrl),
        .flush       (flush),
        .rd_data     (rd_data),
        .rd_ctrl_out (rd_ctrl)
    );

    crmap_match u_match (
        .clk     (clk),
        .rst_n   (rst_n),
        .flush   (flush),
        .ctrl_in (rd_ctrl),
        .entry   (rd_data),
        .addr    (addr_reg),
        .result  (match),
        .sum     (match_sum)
    );

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        issue_next      = issue_reg;
        addr_next       = addr_reg;
        res_found_next  = res_found_reg;
        res_phys_next   = res_phys_reg;
        res_status_next = res_status_reg;
        unique case (state_reg)
            crmap_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    addr_next       = logical_addr;
                    issue_next      = '0;
                    res_found_next  = 1'b0;
                    res_phys_next   = '0;
                    res_status_next = crmap_pkg::STATUS_OK;
                    if (op == crmap_pkg::OP_ADD)
                    begin
                        state_next = crmap_pkg::ST_FINISH;
                        if (stripe_count != crmap_pkg::STRIPES_SUPPORTED)
                        begin
                            res_status_next = crmap_pkg::STATUS_UNSUPPORTED;
                        end
                        else if (!wr_en)
                        begin
                            res_status_next = crmap_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            count_next = count_reg + crmap_pkg::COUNT_W'(1);
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = crmap_pkg::ST_FINISH;
                    end
                    else
                    begin
                        state_next = crmap_pkg::ST_SCAN;
                    end
                end
            end
            crmap_pkg::ST_SCAN:
            begin
                if (rd_en)
                begin
                    issue_next = issue_reg + crmap_pkg::COUNT_W'(1);
                end
                if (scan_done)
                begin
                    state_next     = crmap_pkg::ST_FINISH;
                    res_found_next = match.hit;
                    res_phys_next  = match.hit ? match_sum : '0;
                end
            end
            crmap_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = crmap_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = crmap_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= crmap_pkg::ST_IDLE;
            count_reg     <= '0;
            issue_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            issue_reg <= issue_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        res_found_reg  <= res_found_next;
        res_phys_reg   <= res_phys_next;
        res_status_reg <= res_status_next;
        if (load_out)
        begin
            found_reg    <= res_found_reg;
            phys_out_reg <= res_phys_reg;
            status_reg   <= res_status_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign found         = found_reg;
    assign physical_addr = phys_out_reg;
    assign status        = status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= crmap_pkg::COUNT_W'(crmap_pkg::MAX_ENTRIES))
        else $error("entry count past table depth");

    a_count_only_on_add: assert property (@(posedge clk) disable iff (!rst_n)
        (count_next != count_reg) |-> (in_fire && (op == crmap_pkg::OP_ADD)))
        else $error("entry count moved without an add item");

    a_match_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        match.valid |-> (state_reg == crmap_pkg::ST_SCAN))
        else $error("match stage busy outside a scan");

    a_hit_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && found) |-> (status == crmap_pkg::STATUS_OK))
        else $error("hit reported with a refusal status");

endmodule
